@@ design/tpcts_pkg.sv @@
// Package for the two-partial cue tone synthesizer: constants, register map,
// sequencer states and the elaboration-time quarter-wave sine generator.
// No dependencies.
package tpcts_pkg;

    // Default sizing of the top level
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int ATTACK_SAMPLES_DEF  = 144;

    // Configuration port geometry
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Fixed-point constants
    localparam logic [15:0] GAIN_055    = 16'd36045;    // 0.55 in Q0.16
    localparam logic [15:0] ENV_START   = 16'hFFFF;     // envelope at cue start
    localparam logic [16:0] VOL_UNITY   = 17'd65536;    // volume 1.0
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Register reset values
    localparam logic [30:0] BASE_STEP_RST     = 31'd78741067;
    localparam logic [30:0] OVERTONE_STEP_RST = 31'd118111600;
    localparam logic [15:0] OVERTONE_GAIN_RST = 16'd19661;
    localparam logic [15:0] DECAY_FACTOR_RST  = 16'd65397;
    localparam logic [15:0] CUE_LENGTH_RST    = 16'd2160;
    localparam logic [16:0] VOLUME_RST        = 17'd14418;

    // Register map, word index
    typedef enum logic [2:0] {
        REG_BASE_STEP,
        REG_OVERTONE_STEP,
        REG_BASE_SLIDE,
        REG_OVERTONE_SLIDE,
        REG_OVERTONE_GAIN,
        REG_DECAY_FACTOR,
        REG_CUE_LENGTH,
        REG_VOLUME
    } cfg_reg_t;

    // Per-sample sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_MAIN,
        ST_RD_UPPER,
        ST_MUL_OG,
        ST_MUL_ATT,
        ST_MUL_RCP,
        ST_MUL_G,
        ST_MUL_MIX,
        ST_MUL_VOL,
        ST_MUL_DEC,
        ST_FIN,
        ST_OUT
    } seq_state_t;

    // One Taylor step: divide by (2n)(2n+1)
    function automatic logic [63:0] taylor_div(logic [63:0] t, int n);
        logic [63:0] q;
        case (n)
            1:       q = t / 64'd6;
            2:       q = t / 64'd20;
            3:       q = t / 64'd42;
            4:       q = t / 64'd72;
            5:       q = t / 64'd110;
            6:       q = t / 64'd156;
            default: q = t / 64'd210;
        endcase
        return q;
    endfunction

    // round(32767*sin(pi/2*(k+0.5)/2^bits)), evaluated at elaboration only
    function automatic logic [15:0] quarter_sine(int k, int bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        x    = (HALF_PI_Q30 * 64'(2 * k + 1)) >> (bits + 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int n = 1; n <= 7; n++) begin
            term = taylor_div((term * x2) >> 30, n);
            if (n[0]) sum = sum - signed'(term);
            else      sum = sum + signed'(term);
        end
        if (sum < 0) sum = '0;
        v = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) v = 64'd32767;
        return v[15:0];
    endfunction

endpackage

@@ design/two_partial_cue_tone_synth_core.sv @@
// Two-partial cue tone synthesizer: phase accumulators, sine ROM, envelope and
// one shared multiplier under a sequencer, plus the APB register file.
// Depends on tpcts_pkg.
//
//  channel  | ports                                  | direction
//  ---------+----------------------------------------+----------
//  input    | s_valid s_start_req (s_ready out)      | in
//  result   | m_valid m_sample m_active (m_ready in) | out
//           | m_final_res                            |
//  config   | psel penable pwrite paddr pwdata       | in
//           | prdata pready                          | out
//
// A tick with a cue sounding runs from acceptance to the result register
// through two sine ROM reads and seven products through the single shared
// 33x33 multiplier, one step each. An idle tick goes straight to the output step.
// s_ready is high only while the sequencer is idle; a result held by a low
// m_ready holds the sequencer in its output step.
// Reset (aresetn low, synchronous) stops any cue and restores register defaults.
module two_partial_cue_tone_synth_core #(
    parameter int SINE_TABLE_BITS = tpcts_pkg::SINE_TABLE_BITS_DEF,
    parameter int ATTACK_SAMPLES  = tpcts_pkg::ATTACK_SAMPLES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_start_req,
    // result items
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [15:0]                m_sample,
    output logic                              m_active,
    output logic                              m_final_res,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tpcts_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [tpcts_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [tpcts_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                              pready
);

    localparam int ROM_SIZE   = 1 << SINE_TABLE_BITS;
    localparam int ATT_BITS   = $clog2(ATTACK_SAMPLES);
    localparam int ATT_PROD_W = 16 + ATT_BITS;
    localparam int RCP_SHIFT  = 16 + 2 * ATT_BITS;
    // ceil(2^RCP_SHIFT / ATTACK_SAMPLES): exact floor division for env*i
    localparam logic [63:0] RCP_MULT =
        ((64'd1 << RCP_SHIFT) + 64'(ATTACK_SAMPLES) - 64'd1) / 64'(ATTACK_SAMPLES);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    tpcts_pkg::seq_state_t state_reg, state_next;

    logic [30:0]        base_step_reg, ovt_step_reg;
    logic signed [20:0] base_slide_reg, ovt_slide_reg;
    logic [15:0]        ovt_gain_reg, decay_reg, cue_len_reg;
    logic [16:0]        volume_reg;

    logic [31:0] main_phase_reg, main_phase_next;
    logic [31:0] upper_phase_reg, upper_phase_next;
    logic [31:0] main_inc_reg, main_inc_next;
    logic [31:0] upper_inc_reg, upper_inc_next;
    logic [15:0] envelope_reg, envelope_next;
    logic [15:0] sample_index_reg, sample_index_next;
    logic        playing_reg, playing_next;
    logic        m_valid_reg, m_valid_next;

    logic [15:0]        rom_q_reg;
    logic signed [15:0] sine_m_reg, sine_m_next;
    logic signed [17:0] mix_reg, mix_next;
    logic signed [15:0] res_reg, res_next;
    logic               act_reg, act_next;
    logic               last_reg, last_next;
    logic signed [65:0] prod_reg;

    logic signed [15:0] m_sample_reg;
    logic               m_active_reg, m_final_reg;

    // ------------------------------------------------------------------
    // Sine ROM, contents fixed at elaboration, registered read
    // ------------------------------------------------------------------
    logic [15:0] sine_rom [ROM_SIZE];

    for (genvar k = 0; k < ROM_SIZE; k++) begin : g_rom
        localparam logic [15:0] ROM_VAL = tpcts_pkg::quarter_sine(k, SINE_TABLE_BITS);
        assign sine_rom[k] = ROM_VAL;
    end

    logic                       rd_main;
    logic [31:0]                rd_phase;
    logic [SINE_TABLE_BITS-1:0] rom_addr;

    // second quadrant and fourth quadrant read the table backwards
    assign rd_main  = (state_reg == tpcts_pkg::ST_RD_MAIN);
    assign rd_phase = rd_main ? main_phase_reg : upper_phase_reg;
    assign rom_addr = rd_phase[30] ? ~rd_phase[29 -: SINE_TABLE_BITS]
                                   :  rd_phase[29 -: SINE_TABLE_BITS];

    // sign from the quadrant of the phase whose word sits in rom_q_reg
    logic               quad_neg;
    logic signed [15:0] rom_s, sine_val;

    assign quad_neg = (state_reg == tpcts_pkg::ST_RD_UPPER) ? main_phase_reg[31]
                                                            : upper_phase_reg[31];
    assign rom_s    = signed'(rom_q_reg);
    assign sine_val = quad_neg ? -rom_s : rom_s;

    // ------------------------------------------------------------------
    // Shared multiplier and truncate-toward-zero scaler
    // ------------------------------------------------------------------
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    assign mul_p = mul_a * mul_b;

    logic               trunc_by32;
    logic signed [65:0] trunc_bias, trunc_sum, trunc_q;

    assign trunc_by32 = (state_reg == tpcts_pkg::ST_MUL_VOL);
    assign trunc_bias = !prod_reg[65] ? 66'sd0
                      : (trunc_by32 ? 66'sh0_FFFF_FFFF : 66'sd65535);
    assign trunc_sum  = prod_reg + trunc_bias;
    assign trunc_q    = trunc_by32 ? (trunc_sum >>> 32) : (trunc_sum >>> 16);

    // clamp of the enveloped mix to +-32767
    logic signed [15:0] pcm;

    always_comb begin
        if (trunc_q > 66'sd32767)       pcm = 16'sd32767;
        else if (trunc_q < -66'sd32767) pcm = -16'sd32767;
        else                            pcm = trunc_q[15:0];
    end

    // attack ramp: quotient of env*i, else the plain envelope
    logic        att_phase;
    logic [15:0] env_att;

    assign att_phase = sample_index_reg < 16'(ATTACK_SAMPLES);
    assign env_att   = att_phase ? prod_reg[RCP_SHIFT +: 16] : envelope_reg;

    // envelope decay rounding and cue end test
    logic [32:0] env_dec_sum;
    logic [16:0] idx_plus;

    assign env_dec_sum = {1'b0, prod_reg[31:0]} + 33'd32768;
    assign idx_plus    = {1'b0, sample_index_reg} + 17'd1;

    // volume saturates at unity
    logic [16:0] vol_sat;

    assign vol_sat = (volume_reg > tpcts_pkg::VOL_UNITY) ? tpcts_pkg::VOL_UNITY
                                                         : volume_reg;

    // ------------------------------------------------------------------
    // Tick start: retrigger and phase step
    // ------------------------------------------------------------------
    logic        start_ok;
    logic [31:0] main_phase_cur, upper_phase_cur, main_inc_cur, upper_inc_cur;

    assign start_ok        = s_start_req && (volume_reg != '0) && (cue_len_reg != '0);
    assign main_phase_cur  = start_ok ? '0 : main_phase_reg;
    assign upper_phase_cur = start_ok ? '0 : upper_phase_reg;
    assign main_inc_cur    = start_ok ? {1'b0, base_step_reg} : main_inc_reg;
    assign upper_inc_cur   = start_ok ? {1'b0, ovt_step_reg} : upper_inc_reg;

    logic out_load;

    assign out_load = (state_reg == tpcts_pkg::ST_OUT) && (!m_valid_reg || m_ready);

    // ------------------------------------------------------------------
    // Sequencer: next state, operand select, datapath updates
    // ------------------------------------------------------------------
    always_comb begin
        state_next        = state_reg;
        main_phase_next   = main_phase_reg;
        upper_phase_next  = upper_phase_reg;
        main_inc_next     = main_inc_reg;
        upper_inc_next    = upper_inc_reg;
        envelope_next     = envelope_reg;
        sample_index_next = sample_index_reg;
        playing_next      = playing_reg;
        sine_m_next       = sine_m_reg;
        mix_next          = mix_reg;
        res_next          = res_reg;
        act_next          = act_reg;
        last_next         = last_reg;
        mul_a             = '0;
        mul_b             = '0;
        m_valid_next      = m_valid_reg;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        unique case (state_reg)
            tpcts_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (start_ok || playing_reg) begin
                        main_phase_next  = main_phase_cur + main_inc_cur;
                        upper_phase_next = upper_phase_cur + upper_inc_cur;
                        main_inc_next    = main_inc_cur + 32'(base_slide_reg);
                        upper_inc_next   = upper_inc_cur + 32'(ovt_slide_reg);
                        playing_next     = 1'b1;
                        if (start_ok) begin
                            envelope_next     = tpcts_pkg::ENV_START;
                            sample_index_next = '0;
                        end
                        state_next = tpcts_pkg::ST_RD_MAIN;
                    end else begin
                        // idle tick: silent item
                        res_next   = '0;
                        act_next   = 1'b0;
                        last_next  = 1'b0;
                        state_next = tpcts_pkg::ST_OUT;
                    end
                end
            end
            tpcts_pkg::ST_RD_MAIN: begin
                state_next = tpcts_pkg::ST_RD_UPPER;
            end
            tpcts_pkg::ST_RD_UPPER: begin
                sine_m_next = sine_val;
                state_next  = tpcts_pkg::ST_MUL_OG;
            end
            tpcts_pkg::ST_MUL_OG: begin
                // gain * upper sine
                mul_a      = 33'(ovt_gain_reg);
                mul_b      = 33'(sine_val);
                state_next = tpcts_pkg::ST_MUL_ATT;
            end
            tpcts_pkg::ST_MUL_ATT: begin
                // mix, then envelope * sample index for the ramp
                mix_next   = 18'(sine_m_reg) + trunc_q[17:0];
                mul_a      = 33'(envelope_reg);
                mul_b      = 33'(sample_index_reg);
                state_next = tpcts_pkg::ST_MUL_RCP;
            end
            tpcts_pkg::ST_MUL_RCP: begin
                // divide by the attack length via its reciprocal
                mul_a      = 33'(prod_reg[ATT_PROD_W-1:0]);
                mul_b      = 33'(RCP_MULT);
                state_next = tpcts_pkg::ST_MUL_G;
            end
            tpcts_pkg::ST_MUL_G: begin
                mul_a      = 33'(env_att);
                mul_b      = 33'(tpcts_pkg::GAIN_055);
                state_next = tpcts_pkg::ST_MUL_MIX;
            end
            tpcts_pkg::ST_MUL_MIX: begin
                mul_a      = 33'(mix_reg);
                mul_b      = 33'(prod_reg[31:0]);
                state_next = tpcts_pkg::ST_MUL_VOL;
            end
            tpcts_pkg::ST_MUL_VOL: begin
                mul_a      = 33'(pcm);
                mul_b      = 33'(vol_sat);
                state_next = tpcts_pkg::ST_MUL_DEC;
            end
            tpcts_pkg::ST_MUL_DEC: begin
                res_next   = trunc_q[15:0];
                act_next   = 1'b1;
                mul_a      = 33'(envelope_reg);
                mul_b      = 33'(decay_reg);
                state_next = tpcts_pkg::ST_FIN;
            end
            tpcts_pkg::ST_FIN: begin
                envelope_next     = env_dec_sum[31:16];
                last_next         = idx_plus >= {1'b0, cue_len_reg};
                sample_index_next = idx_plus[15:0];
                if (idx_plus >= {1'b0, cue_len_reg}) playing_next = 1'b0;
                state_next        = tpcts_pkg::ST_OUT;
            end
            tpcts_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = tpcts_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tpcts_pkg::ST_IDLE;
            end
        endcase
    end

    // control and model state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= tpcts_pkg::ST_IDLE;
            main_phase_reg   <= '0;
            upper_phase_reg  <= '0;
            main_inc_reg     <= '0;
            upper_inc_reg    <= '0;
            envelope_reg     <= '0;
            sample_index_reg <= '0;
            playing_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            main_phase_reg   <= main_phase_next;
            upper_phase_reg  <= upper_phase_next;
            main_inc_reg     <= main_inc_next;
            upper_inc_reg    <= upper_inc_next;
            envelope_reg     <= envelope_next;
            sample_index_reg <= sample_index_next;
            playing_reg      <= playing_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // datapath and result payload
    always_ff @(posedge aclk) begin
        rom_q_reg  <= sine_rom[rom_addr];
        prod_reg   <= mul_p;
        sine_m_reg <= sine_m_next;
        mix_reg    <= mix_next;
        res_reg    <= res_next;
        act_reg    <= act_next;
        last_reg   <= last_next;
        if (out_load) begin
            m_sample_reg <= res_reg;
            m_active_reg <= act_reg;
            m_final_reg  <= last_reg;
        end
    end

    assign s_ready     = (state_reg == tpcts_pkg::ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_sample    = m_sample_reg;
    assign m_active    = m_active_reg;
    assign m_final_res = m_final_reg;

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    tpcts_pkg::cfg_reg_t cfg_sel;
    logic                cfg_wr;

    assign cfg_sel = tpcts_pkg::cfg_reg_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_step_reg  <= tpcts_pkg::BASE_STEP_RST;
            ovt_step_reg   <= tpcts_pkg::OVERTONE_STEP_RST;
            base_slide_reg <= '0;
            ovt_slide_reg  <= '0;
            ovt_gain_reg   <= tpcts_pkg::OVERTONE_GAIN_RST;
            decay_reg      <= tpcts_pkg::DECAY_FACTOR_RST;
            cue_len_reg    <= tpcts_pkg::CUE_LENGTH_RST;
            volume_reg     <= tpcts_pkg::VOLUME_RST;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                tpcts_pkg::REG_BASE_STEP:      base_step_reg  <= pwdata[30:0];
                tpcts_pkg::REG_OVERTONE_STEP:  ovt_step_reg   <= pwdata[30:0];
                tpcts_pkg::REG_BASE_SLIDE:     base_slide_reg <= pwdata[20:0];
                tpcts_pkg::REG_OVERTONE_SLIDE: ovt_slide_reg  <= pwdata[20:0];
                tpcts_pkg::REG_OVERTONE_GAIN:  ovt_gain_reg   <= pwdata[15:0];
                tpcts_pkg::REG_DECAY_FACTOR:   decay_reg      <= pwdata[15:0];
                tpcts_pkg::REG_CUE_LENGTH:     cue_len_reg    <= pwdata[15:0];
                tpcts_pkg::REG_VOLUME:         volume_reg     <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    // read-back, slides sign-extended
    always_comb begin
        unique case (cfg_sel)
            tpcts_pkg::REG_BASE_STEP:      prdata = 32'(base_step_reg);
            tpcts_pkg::REG_OVERTONE_STEP:  prdata = 32'(ovt_step_reg);
            tpcts_pkg::REG_BASE_SLIDE:     prdata = 32'(base_slide_reg);
            tpcts_pkg::REG_OVERTONE_SLIDE: prdata = 32'(ovt_slide_reg);
            tpcts_pkg::REG_OVERTONE_GAIN:  prdata = 32'(ovt_gain_reg);
            tpcts_pkg::REG_DECAY_FACTOR:   prdata = 32'(decay_reg);
            tpcts_pkg::REG_CUE_LENGTH:     prdata = 32'(cue_len_reg);
            tpcts_pkg::REG_VOLUME:         prdata = 32'(volume_reg);
            default:                       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_silent_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_active |-> (m_sample == '0) && !m_final_res)
        else $error("idle item carries a nonzero sample or end flag");

    a_final_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_final_res |-> m_active)
        else $error("cue end flagged on an idle item");

    a_seq_playing: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tpcts_pkg::ST_RD_MAIN |-> playing_reg)
        else $error("sample sequence running without a cue");

    a_out_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == tpcts_pkg::ST_OUT)
        else $error("result raised outside the output step");

endmodule

@@ bench/tone_checker.sv @@
// Result checker for the two-partial cue tone synthesizer: follows register
// writes, models every accepted sample tick and compares the produced samples.
// Depends on tpcts_pkg.
module tone_checker
    import tpcts_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_start_req,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic signed [15:0]    m_sample,
    input  logic                  m_active,
    input  logic                  m_final_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    fail_count,
    output int                    pending,
    output int                    results_checked,
    output int                    cues_ended
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_BITS   = SINE_TABLE_BITS_DEF;
    localparam int TBL_SIZE   = 1 << TBL_BITS;
    localparam int ATTACK     = ATTACK_SAMPLES_DEF;
    localparam int MAX_PRINTS = 20;

    typedef struct {
        int unsigned        tick;
        logic signed [15:0] sample;
        logic               active;
        logic               last;
    } tone_t;

    // register copies
    logic [31:0] cfg_base_step;
    logic [31:0] cfg_over_step;
    logic [31:0] cfg_base_slide;
    logic [31:0] cfg_over_slide;
    int unsigned cfg_gain;
    int unsigned cfg_decay;
    int unsigned cfg_length;
    int unsigned cfg_volume;

    // synth state
    logic [31:0] main_ph;
    logic [31:0] over_ph;
    logic [31:0] main_inc;
    logic [31:0] over_inc;
    int unsigned env_level;
    int unsigned pos;
    logic        sounding;
    logic [15:0] quarter_wave [TBL_SIZE];

    tone_t       tones_due [$];
    tone_t       fresh;
    tone_t       want;
    int unsigned ticks_seen = 0;
    int          errors     = 0;
    int          results_n  = 0;
    int          cue_ends   = 0;

    // Quarter-wave entry: Taylor series of sin at the bin center, Q30
    function automatic logic [15:0] wave_entry(int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint          sum;
        x    = (HALF_PI_Q30 * (2 * k + 1)) / (2 * TBL_SIZE);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n % 2) sum = sum - term;
            else       sum = sum + term;
        end
        if (sum < 0) sum = 0;
        v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 32767) v = 32767;
        return v[15:0];
    endfunction

    initial begin
        for (int k = 0; k < TBL_SIZE; k++) quarter_wave[TBL_BITS'(k)] = wave_entry(k);
    end

    // Full-wave lookup from the quarter table, mirrored and negated by quadrant
    function automatic int wave_at(logic [31:0] ph);
        logic [TBL_BITS-1:0] slot;
        int                  mag;
        slot = ph[29 -: TBL_BITS];
        if (ph[30]) slot = ~slot;
        mag = int'(quarter_wave[slot]);
        return ph[31] ? -mag : mag;
    endfunction

    // Register write: bits above each register's width are dropped
    task automatic load_setting(input cfg_reg_t r, input logic [31:0] d);
        case (r)
            REG_BASE_STEP:      cfg_base_step  = {1'b0, d[30:0]};
            REG_OVERTONE_STEP:  cfg_over_step  = {1'b0, d[30:0]};
            REG_BASE_SLIDE:     cfg_base_slide = {{11{d[20]}}, d[20:0]};
            REG_OVERTONE_SLIDE: cfg_over_slide = {{11{d[20]}}, d[20:0]};
            REG_OVERTONE_GAIN:  cfg_gain       = 32'(d[15:0]);
            REG_DECAY_FACTOR:   cfg_decay      = 32'(d[15:0]);
            REG_CUE_LENGTH:     cfg_length     = 32'(d[15:0]);
            REG_VOLUME:         cfg_volume     = 32'(d[16:0]);
            default: ;
        endcase
    endtask

    // One sample tick of the synthesizer
    task automatic next_tone(input logic start, output tone_t t);
        int unsigned vol;
        int unsigned env;
        longint      mix;
        longint      pcm;
        longint      level;
        vol      = (cfg_volume > 65536) ? 65536 : cfg_volume;
        t.tick   = ticks_seen;
        t.sample = '0;
        t.active = 1'b0;
        t.last   = 1'b0;
        // start is dropped while silenced or with zero length
        if (start && vol != 0 && cfg_length != 0) begin
            sounding  = 1'b1;
            main_ph   = '0;
            over_ph   = '0;
            main_inc  = cfg_base_step;
            over_inc  = cfg_over_step;
            env_level = 65535;
            pos       = 0;
        end
        if (sounding) begin
            main_ph  = main_ph + main_inc;
            over_ph  = over_ph + over_inc;
            main_inc = main_inc + cfg_base_slide;
            over_inc = over_inc + cfg_over_slide;
            mix = longint'(wave_at(main_ph))
                + (longint'(cfg_gain) * longint'(wave_at(over_ph))) / 64'sd65536;
            // linear attack over the first samples
            env = env_level;
            if (pos < ATTACK) env = (env * pos) / ATTACK;
            pcm = (mix * longint'(env) * longint'(GAIN_055)) / 64'sd4294967296;
            if (pcm > 32767)       pcm = 32767;
            else if (pcm < -32767) pcm = -32767;
            level = (pcm * longint'(vol)) / 64'sd65536;
            // envelope decay with rounding, fits 32 bits
            env_level = ((env_level * cfg_decay + 32768) >> 16) & 32'hFFFF;
            t.last    = (pos + 1) >= cfg_length;
            pos       = (pos + 1) & 32'hFFFF;
            if (t.last) sounding = 1'b0;
            t.sample = level[15:0];
            t.active = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (errors < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_base_step  = {1'b0, BASE_STEP_RST};
            cfg_over_step  = {1'b0, OVERTONE_STEP_RST};
            cfg_base_slide = '0;
            cfg_over_slide = '0;
            cfg_gain       = 32'(OVERTONE_GAIN_RST);
            cfg_decay      = 32'(DECAY_FACTOR_RST);
            cfg_length     = 32'(CUE_LENGTH_RST);
            cfg_volume     = 32'(VOLUME_RST);
            main_ph        = '0;
            over_ph        = '0;
            main_inc       = '0;
            over_inc       = '0;
            env_level      = 0;
            pos            = 0;
            sounding       = 1'b0;
            ticks_seen     = 0;
            tones_due.delete();
        end else begin
            if (psel && penable && pwrite && pready)
                load_setting(cfg_reg_t'(paddr[CFG_ADDR_W-1:2]), pwdata);
            // compare the produced sample with the oldest prediction
            if (m_valid && m_ready) begin
                results_n++;
                if (tones_due.size() == 0) begin
                    report_mismatch("sample item with no tick waiting");
                end else begin
                    want = tones_due.pop_front();
                    if (want.last) cue_ends++;
                    if (m_sample !== want.sample)
                        report_mismatch($sformatf("tick %0d sample %0d, expected %0d",
                                                  want.tick, m_sample, want.sample));
                    if (m_active !== want.active)
                        report_mismatch($sformatf("tick %0d active %b, expected %b",
                                                  want.tick, m_active, want.active));
                    if (m_final_res !== want.last)
                        report_mismatch($sformatf("tick %0d final_res %b, expected %b",
                                                  want.tick, m_final_res, want.last));
                end
            end
            if (s_valid && s_ready) begin
                next_tone(s_start_req, fresh);
                tones_due.push_back(fresh);
                ticks_seen++;
            end
        end
        fail_count      <= errors;
        pending         <= tones_due.size();
        results_checked <= results_n;
        cues_ended      <= cue_ends;
    end

endmodule

@@ bench/testbench.sv @@
// Top of the cue tone synthesizer bench: clock, reset, register writes,
// sample tick stimulus with random idling and the final verdict.
// Depends on tpcts_pkg, two_partial_cue_tone_synth_core and tone_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tpcts_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 10;
    localparam int IDLE_PCT       = 24;
    localparam int RANDOM_TICKS   = 1100;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int STEADY_PHASE   = 4;
    localparam int HOLD_PHASE     = 7;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic                  s_start_req = 1'b0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic signed [15:0]    m_sample;
    logic                  m_active;
    logic                  m_final_res;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr       = '0;
    logic [CFG_DATA_W-1:0] pwdata      = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int   fail_count;
    int   pending;
    int   results_checked;
    int   cues_ended;
    int   ticks_sent   = 0;
    int   phases       = 0;
    int   quiet_cycles = 0;
    logic steady       = 1'b0;
    logic stall_go     = 1'b0;
    logic stall_done   = 1'b0;

    two_partial_cue_tone_synth_core i_dut (.*);

    tone_checker i_tone_check (.*);

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // APB write: setup cycle, access cycle, then release
    task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // One tick item; valid stays high across back-to-back items
    task automatic send_tick(input logic start);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_start_req <= start;
        do @(posedge aclk); while (!s_ready);
        ticks_sent++;
    endtask

    // Stop offering, wait for every sample due, then let the sequencer finish
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Receiver: random back-pressure, one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_go && !stall_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                stall_done <= 1'b1;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog on any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [31:0] v;
        int          first_random;
        int          start_pm;
        int          burst;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Defaults: an idle tick, then a cue start and a few attack samples
        send_tick(1'b0);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        settle();
        // Shortening the length while a cue sounds ends it on the next sample
        write_reg(REG_CUE_LENGTH, 32'd3);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        settle();
        // Start with zero volume is dropped
        write_reg(REG_VOLUME, 32'd0);
        send_tick(1'b1);
        settle();
        // Extremes with stray upper bits; volume beyond unity saturates
        write_reg(REG_VOLUME, 32'hFFFF_FFFF);
        write_reg(REG_CUE_LENGTH, 32'hABCD_00C8);
        write_reg(REG_BASE_STEP, 32'hFFFF_FFFF);
        write_reg(REG_OVERTONE_STEP, 32'd0);
        write_reg(REG_BASE_SLIDE, 32'h0010_0000);
        write_reg(REG_OVERTONE_SLIDE, 32'hFFEF_FFFF);
        write_reg(REG_OVERTONE_GAIN, 32'hFFFF_FFFF);
        write_reg(REG_DECAY_FACTOR, 32'd0);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        settle();
        // Zero length: start dropped, the sounding cue ends at once
        write_reg(REG_CUE_LENGTH, 32'hFFFF_0000);
        send_tick(1'b1);
        settle();
        // Opposite extremes, then a restart while the cue sounds
        write_reg(REG_CUE_LENGTH, 32'd65535);
        write_reg(REG_DECAY_FACTOR, 32'd65535);
        write_reg(REG_OVERTONE_GAIN, 32'd0);
        write_reg(REG_BASE_STEP, 32'd0);
        write_reg(REG_OVERTONE_STEP, 32'h7FFF_FFFF);
        write_reg(REG_BASE_SLIDE, 32'h000F_FFFF);
        write_reg(REG_OVERTONE_SLIDE, 32'h0010_0000);
        write_reg(REG_VOLUME, 32'd65536);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);

        // Random phases: new settings, then a burst of ticks
        first_random = ticks_sent;
        while (ticks_sent - first_random < RANDOM_TICKS) begin
            settle();
            phases++;
            steady <= (phases == STEADY_PHASE);
            if (phases == HOLD_PHASE) stall_go <= 1'b1;

            case ($urandom_range(3))
                0:       v = 32'd0;
                1:       v = 32'h7FFF_FFFF;
                2:       v = $urandom_range(200_000_000, 20_000_000);
                default: v = $urandom();
            endcase
            write_reg(REG_BASE_STEP, v);
            case ($urandom_range(3))
                0:       v = 32'd0;
                1:       v = 32'h7FFF_FFFF;
                2:       v = $urandom_range(300_000_000, 20_000_000);
                default: v = $urandom();
            endcase
            write_reg(REG_OVERTONE_STEP, v);
            case ($urandom_range(4))
                0:       v = 32'h0010_0000;
                1:       v = 32'h000F_FFFF;
                2:       v = 32'd0;
                3:       v = $urandom_range(4000) - 2000;
                default: v = $urandom();
            endcase
            write_reg(REG_BASE_SLIDE, v);
            case ($urandom_range(4))
                0:       v = 32'h0010_0000;
                1:       v = 32'h000F_FFFF;
                2:       v = 32'd0;
                3:       v = $urandom_range(4000) - 2000;
                default: v = $urandom();
            endcase
            write_reg(REG_OVERTONE_SLIDE, v);
            case ($urandom_range(2))
                0:       v = 32'd0;
                1:       v = 32'd65535;
                default: v = $urandom();
            endcase
            write_reg(REG_OVERTONE_GAIN, v);
            case ($urandom_range(3))
                0:       v = 32'd0;
                1:       v = 32'd65535;
                2:       v = $urandom_range(65535, 64000);
                default: v = $urandom();
            endcase
            write_reg(REG_DECAY_FACTOR, v);
            // mostly short cues so that many reach their end
            case ($urandom_range(9))
                0:       v = 32'd0;
                1:       v = 32'd65535;
                2:       v = $urandom_range(400, 145);
                3:       v = $urandom();
                default: v = $urandom_range(60, 1);
            endcase
            write_reg(REG_CUE_LENGTH, v);
            case ($urandom_range(7))
                0:       v = 32'd0;
                1:       v = 32'd65536;
                2:       v = $urandom_range(131071, 65537);
                3:       v = $urandom();
                default: v = $urandom_range(65536, 1);
            endcase
            write_reg(REG_VOLUME, v);

            case ($urandom_range(3))
                0:       start_pm = 0;
                1:       start_pm = 10;
                2:       start_pm = 60;
                default: start_pm = 300;
            endcase
            burst = (phases == STEADY_PHASE) ? 200 : $urandom_range(80, 30);
            repeat (burst) send_tick($urandom_range(999) < start_pm);
        end
        settle();

        $display("covered %0d sample ticks over %0d random register settings, %0d samples checked",
                 ticks_sent, phases, results_checked);
        $display("%0d cues ran to their last sample; one receiver hold-off of %0d cycles",
                 cues_ended, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/tpcts_pkg.sv
design/two_partial_cue_tone_synth_core.sv
bench/tone_checker.sv
bench/testbench.sv
